>>> hw/rtl/qsam_pkg.sv
// Shared types, widths and helpers for the quaternion/scale to affine matrix pipeline.
// No dependencies; every pipeline stage and the top level import this package.
package qsam_pkg;

    localparam int QUAT_FRAC_BITS = 14;
    localparam int OUT_W          = 32;
    localparam int FRAC_SHIFT     = 2 * QUAT_FRAC_BITS - 8;

    localparam int Q_W     = 16;               // quaternion component
    localparam int SC_W    = 16;               // scale, Q8.8
    localparam int POS_W   = 32;               // position, Q16.16
    localparam int PROD_W  = 2 * Q_W;          // pairwise product
    localparam int SUM_W   = PROD_W + 1;       // sum of two products
    localparam int MUL_W   = SUM_W + SC_W + 1; // doubled product with the scale
    localparam int ACC_W   = MUL_W + 1;        // rounding headroom
    localparam int N_ENT   = 9;                // rotation/scale entries
    localparam int IN_DW   = 7 * Q_W + 3 * POS_W;
    localparam int OUT_DW  = 12 * OUT_W;

    // Entry order: c0_r0, c0_r1, c0_r2, c1_r0, c1_r1, c1_r2, c2_r0, c2_r1, c2_r2
    localparam int E_C0R0 = 0;
    localparam int E_C0R1 = 1;
    localparam int E_C0R2 = 2;
    localparam int E_C1R0 = 3;
    localparam int E_C1R1 = 4;
    localparam int E_C1R2 = 5;
    localparam int E_C2R0 = 6;
    localparam int E_C2R1 = 7;
    localparam int E_C2R2 = 8;

    typedef struct packed {
        logic signed [Q_W-1:0]   x;
        logic signed [Q_W-1:0]   y;
        logic signed [Q_W-1:0]   z;
        logic signed [Q_W-1:0]   w;
        logic signed [SC_W-1:0]  sx;
        logic signed [SC_W-1:0]  sy;
        logic signed [SC_W-1:0]  sz;
        logic signed [POS_W-1:0] px;
        logic signed [POS_W-1:0] py;
        logic signed [POS_W-1:0] pz;
    } t_in;

    typedef struct packed {
        logic signed [PROD_W-1:0] xx;
        logic signed [PROD_W-1:0] xy;
        logic signed [PROD_W-1:0] xz;
        logic signed [PROD_W-1:0] xw;
        logic signed [PROD_W-1:0] yy;
        logic signed [PROD_W-1:0] yz;
        logic signed [PROD_W-1:0] yw;
        logic signed [PROD_W-1:0] zz;
        logic signed [PROD_W-1:0] zw;
        logic signed [SC_W-1:0]   sx;
        logic signed [SC_W-1:0]   sy;
        logic signed [SC_W-1:0]   sz;
        logic signed [POS_W-1:0]  px;
        logic signed [POS_W-1:0]  py;
        logic signed [POS_W-1:0]  pz;
    } t_prod;

    typedef struct packed {
        logic [N_ENT-1:0][SUM_W-1:0] sum;  // diagonal entries hold the negated sum
        logic signed [SC_W-1:0]      sx;
        logic signed [SC_W-1:0]      sy;
        logic signed [SC_W-1:0]      sz;
        logic signed [POS_W-1:0]     px;
        logic signed [POS_W-1:0]     py;
        logic signed [POS_W-1:0]     pz;
    } t_sum;

    typedef struct packed {
        logic [N_ENT-1:0][MUL_W-1:0] mul;
        logic signed [SC_W-1:0]      sx;
        logic signed [SC_W-1:0]      sy;
        logic signed [SC_W-1:0]      sz;
        logic signed [POS_W-1:0]     px;
        logic signed [POS_W-1:0]     py;
        logic signed [POS_W-1:0]     pz;
    } t_mul;

    typedef struct packed {
        logic [N_ENT-1:0][OUT_W-1:0] ent;
        logic signed [OUT_W-1:0]     tx;
        logic signed [OUT_W-1:0]     ty;
        logic signed [OUT_W-1:0]     tz;
    } t_out;

    // Clamp to the signed OUT_W range.
    function automatic logic [OUT_W-1:0] sat_out(input logic signed [ACC_W-1:0] v);
        logic [ACC_W-OUT_W:0] top;
        logic [OUT_W-1:0]     res;
        top = v[ACC_W-1:OUT_W-1];
        if ((&top) || !(|top)) begin
            res = v[OUT_W-1:0];
        end else if (v[ACC_W-1]) begin
            res = {1'b1, {(OUT_W-1){1'b0}}};
        end else begin
            res = {1'b0, {(OUT_W-1){1'b1}}};
        end
        return res;
    endfunction

endpackage

>>> hw/rtl/quaternion_scale_to_affine_matrix_core.sv
// TRS transform to affine matrix: quaternion rotation, per-axis scale, position.
// One word per cycle sustained while m_axis_tready stays high.
// Four register stages (products, sums, scale multiply, round/saturate), each with its own
// valid bit; a stage loads whenever it is empty or the next one takes its word.
// Synchronous active-low reset clears the valid bits only; the data path is not reset.
// Depends on qsam_pkg, qsam_prod, qsam_sum, qsam_scale, qsam_round.
module quaternion_scale_to_affine_matrix_core (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         s_axis_tvalid,
    output logic                         s_axis_tready,
    // quat_x, quat_y, quat_z, quat_w, scale_x, scale_y, scale_z, pos_x, pos_y, pos_z
    input  logic [qsam_pkg::IN_DW-1:0]   s_axis_tdata,
    output logic                         m_axis_tvalid,
    input  logic                         m_axis_tready,
    // c0_r0, c0_r1, c0_r2, c1_r0, c1_r1, c1_r2, c2_r0, c2_r1, c2_r2, trans_x, trans_y, trans_z
    output logic [qsam_pkg::OUT_DW-1:0]  m_axis_tdata
);
    import qsam_pkg::*;

    t_in   in_word;
    t_prod prod_data;
    t_sum  sum_data;
    t_mul  mul_data;
    t_out  out_word;
    logic  prod_vld, sum_vld, mul_vld;
    logic  sum_rdy, mul_rdy, rnd_rdy;

    assign in_word.x  = s_axis_tdata[0*Q_W +: Q_W];
    assign in_word.y  = s_axis_tdata[1*Q_W +: Q_W];
    assign in_word.z  = s_axis_tdata[2*Q_W +: Q_W];
    assign in_word.w  = s_axis_tdata[3*Q_W +: Q_W];
    assign in_word.sx = s_axis_tdata[4*Q_W +: SC_W];
    assign in_word.sy = s_axis_tdata[4*Q_W + SC_W +: SC_W];
    assign in_word.sz = s_axis_tdata[4*Q_W + 2*SC_W +: SC_W];
    assign in_word.px = s_axis_tdata[4*Q_W + 3*SC_W +: POS_W];
    assign in_word.py = s_axis_tdata[4*Q_W + 3*SC_W + POS_W +: POS_W];
    assign in_word.pz = s_axis_tdata[4*Q_W + 3*SC_W + 2*POS_W +: POS_W];

    qsam_prod u_prod (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (s_axis_tvalid),
        .o_rdy   (s_axis_tready),
        .i_data  (in_word),
        .o_vld   (prod_vld),
        .i_rdy   (sum_rdy),
        .o_data  (prod_data)
    );

    qsam_sum u_sum (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (prod_vld),
        .o_rdy   (sum_rdy),
        .i_data  (prod_data),
        .o_vld   (sum_vld),
        .i_rdy   (mul_rdy),
        .o_data  (sum_data)
    );

    qsam_scale u_scale (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (sum_vld),
        .o_rdy   (mul_rdy),
        .i_data  (sum_data),
        .o_vld   (mul_vld),
        .i_rdy   (rnd_rdy),
        .o_data  (mul_data)
    );

    qsam_round u_round (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (mul_vld),
        .o_rdy   (rnd_rdy),
        .i_data  (mul_data),
        .o_vld   (m_axis_tvalid),
        .i_rdy   (m_axis_tready),
        .o_data  (out_word)
    );

    // pack entries first, lowest bits up, then the translation column
    for (genvar g = 0; g < N_ENT; g++) begin : g_pack
        assign m_axis_tdata[g*OUT_W +: OUT_W] = out_word.ent[g];
    end
    assign m_axis_tdata[9*OUT_W  +: OUT_W] = out_word.tx;
    assign m_axis_tdata[10*OUT_W +: OUT_W] = out_word.ty;
    assign m_axis_tdata[11*OUT_W +: OUT_W] = out_word.tz;

endmodule

>>> hw/rtl/qsam_prod.sv
// First stage: the nine pairwise quaternion products, scale and position carried along.
// Depends on qsam_pkg.
module qsam_prod (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_vld,
    output logic            o_rdy,
    input  qsam_pkg::t_in   i_data,
    output logic            o_vld,
    input  logic            i_rdy,
    output qsam_pkg::t_prod o_data
);
    import qsam_pkg::*;

    logic  r_vld;
    t_prod r_data;
    t_prod n_data;
    logic  adv;

    assign adv   = !r_vld || i_rdy;
    assign o_rdy = adv;
    assign o_vld = r_vld;
    assign o_data = r_data;

    always_comb begin
        n_data.xx = i_data.x * i_data.x;
        n_data.xy = i_data.x * i_data.y;
        n_data.xz = i_data.x * i_data.z;
        n_data.xw = i_data.x * i_data.w;
        n_data.yy = i_data.y * i_data.y;
        n_data.yz = i_data.y * i_data.z;
        n_data.yw = i_data.y * i_data.w;
        n_data.zz = i_data.z * i_data.z;
        n_data.zw = i_data.z * i_data.w;
        n_data.sx = i_data.sx;
        n_data.sy = i_data.sy;
        n_data.sz = i_data.sz;
        n_data.px = i_data.px;
        n_data.py = i_data.py;
        n_data.pz = i_data.pz;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (adv) begin
            r_vld <= i_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv && i_vld) begin
            r_data <= n_data;
        end
    end

endmodule

>>> hw/rtl/qsam_sum.sv
// Second stage: sums and differences of the products for each matrix entry.
// Depends on qsam_pkg.
module qsam_sum (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_vld,
    output logic            o_rdy,
    input  qsam_pkg::t_prod i_data,
    output logic            o_vld,
    input  logic            i_rdy,
    output qsam_pkg::t_sum  o_data
);
    import qsam_pkg::*;

    logic r_vld;
    t_sum r_data;
    t_sum n_data;
    logic adv;

    logic signed [SUM_W-1:0] xx, xy, xz, xw, yy, yz, yw, zz, zw;

    assign adv    = !r_vld || i_rdy;
    assign o_rdy  = adv;
    assign o_vld  = r_vld;
    assign o_data = r_data;

    assign xx = SUM_W'(i_data.xx);
    assign xy = SUM_W'(i_data.xy);
    assign xz = SUM_W'(i_data.xz);
    assign xw = SUM_W'(i_data.xw);
    assign yy = SUM_W'(i_data.yy);
    assign yz = SUM_W'(i_data.yz);
    assign yw = SUM_W'(i_data.yw);
    assign zz = SUM_W'(i_data.zz);
    assign zw = SUM_W'(i_data.zw);

    always_comb begin
        // negate the diagonal sums here so the next stage only multiplies
        n_data.sum[E_C0R0] = -(yy + zz);
        n_data.sum[E_C0R1] = xy + zw;
        n_data.sum[E_C0R2] = xz - yw;
        n_data.sum[E_C1R0] = xy - zw;
        n_data.sum[E_C1R1] = -(xx + zz);
        n_data.sum[E_C1R2] = yz + xw;
        n_data.sum[E_C2R0] = xz + yw;
        n_data.sum[E_C2R1] = yz - xw;
        n_data.sum[E_C2R2] = -(xx + yy);
        n_data.sx = i_data.sx;
        n_data.sy = i_data.sy;
        n_data.sz = i_data.sz;
        n_data.px = i_data.px;
        n_data.py = i_data.py;
        n_data.pz = i_data.pz;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (adv) begin
            r_vld <= i_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv && i_vld) begin
            r_data <= n_data;
        end
    end

endmodule

>>> hw/rtl/qsam_scale.sv
// Third stage: doubled entry sums times the column's axis scale, exact.
// Depends on qsam_pkg.
module qsam_scale (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_vld,
    output logic           o_rdy,
    input  qsam_pkg::t_sum i_data,
    output logic           o_vld,
    input  logic           i_rdy,
    output qsam_pkg::t_mul o_data
);
    import qsam_pkg::*;

    logic r_vld;
    t_mul r_data;
    t_mul n_data;
    logic adv;

    assign adv    = !r_vld || i_rdy;
    assign o_rdy  = adv;
    assign o_vld  = r_vld;
    assign o_data = r_data;

    for (genvar g = 0; g < N_ENT; g++) begin : g_ent
        localparam int Col = g / 3;
        logic signed [SC_W-1:0]       sc;
        logic signed [SUM_W-1:0]      sm;
        logic signed [SUM_W+SC_W-1:0] prod;

        assign sc   = (Col == 0) ? i_data.sx : ((Col == 1) ? i_data.sy : i_data.sz);
        assign sm   = $signed(i_data.sum[g]);
        assign prod = sm * sc;
        assign n_data.mul[g] = {prod, 1'b0};
    end

    assign n_data.sx = i_data.sx;
    assign n_data.sy = i_data.sy;
    assign n_data.sz = i_data.sz;
    assign n_data.px = i_data.px;
    assign n_data.py = i_data.py;
    assign n_data.pz = i_data.pz;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (adv) begin
            r_vld <= i_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv && i_vld) begin
            r_data <= n_data;
        end
    end

endmodule

>>> hw/rtl/qsam_round.sv
// Last stage: round half up to Q16.16, add the column's scale on the diagonal, saturate; output register.
// Depends on qsam_pkg.
module qsam_round (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_vld,
    output logic           o_rdy,
    input  qsam_pkg::t_mul i_data,
    output logic           o_vld,
    input  logic           i_rdy,
    output qsam_pkg::t_out o_data
);
    import qsam_pkg::*;

    logic r_vld;
    t_out r_data;
    t_out n_data;
    logic adv;

    assign adv    = !r_vld || i_rdy;
    assign o_rdy  = adv;
    assign o_vld  = r_vld;
    assign o_data = r_data;

    for (genvar g = 0; g < N_ENT; g++) begin : g_ent
        localparam int  Col  = g / 3;
        localparam bit  Diag = (g % 4) == 0;
        logic signed [SC_W-1:0]  sc;
        logic signed [ACC_W-1:0] rnd;
        logic signed [ACC_W-1:0] one;
        logic signed [ACC_W-1:0] acc;

        assign sc  = (Col == 0) ? i_data.sx : ((Col == 1) ? i_data.sy : i_data.sz);
        // floor shift after adding half an LSB
        assign rnd = (ACC_W'($signed(i_data.mul[g])) + (ACC_W'(1) <<< (FRAC_SHIFT - 1)))
                     >>> FRAC_SHIFT;
        assign one = Diag ? (ACC_W'(sc) <<< 8) : '0;
        assign acc = rnd + one;
        assign n_data.ent[g] = sat_out(acc);
    end

    assign n_data.tx = sat_out(ACC_W'(i_data.px));
    assign n_data.ty = sat_out(ACC_W'(i_data.py));
    assign n_data.tz = sat_out(ACC_W'(i_data.pz));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (adv) begin
            r_vld <= i_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv && i_vld) begin
            r_data <= n_data;
        end
    end

endmodule
